// ===== rtl/pcxrle_pkg.sv =====
package pcxrle_pkg;

  // Input commands
  localparam logic [1:0] CMD_DATA    = 2'd0;
  localparam logic [1:0] CMD_END     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_ZERO_RUN  = 2'd1;
  localparam logic [1:0] ERR_PAST_LINE = 2'd2;
  localparam logic [1:0] ERR_EARLY_END = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_BYTES_PER_LINE = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd2;

  // Run byte marker in the top two bits, count in the low six
  localparam logic [1:0] RUN_MARK = 2'b11;
  localparam int unsigned RUN_BITS = 6;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  color;
    logic [15:0] row;
    logic [15:0] column;
    logic [1:0]  error_code;
    logic        last;
  } out_t;

endpackage

// ===== rtl/pcx_rle_scanline_decoder_top.sv =====
// A data byte is taken in S_IDLE, checked in S_CHECK and set up in S_LINE; S_PIX then gives
// one visible pixel per cycle while the output slot is free, then S_FIN gives image complete.
// A run count byte is checked and stored; an error goes out from S_ERR. Restart, unused commands
// and requests while halted are taken in S_IDLE; input is taken only there, so a byte waits.
// Reset (rst_ni low, asynchronous): position, run and halt state cleared, all three
// registers set to 1, no result pending.
module pcx_rle_scanline_decoder_top
  import pcxrle_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LINE,
    S_PIX,
    S_FIN,
    S_ERR
  } state_e;

  state_e              state_q;
  logic [15:0]         width_q, bpl_q, height_q;
  logic [15:0]         row_q, col_q;
  logic [RUN_BITS-1:0] pending_q;
  logic                awaiting_q, halted_q;
  logic [7:0]          byte_q;
  logic [1:0]          err_q;
  logic [15:0]         end_q, stop_q, j_q;
  logic                line_end_q, done_q;
  logic                out_valid_q;
  out_t                out_q;

  logic                slot_free;
  logic                emit;
  logic                is_run;
  logic [RUN_BITS-1:0] cnt;
  logic [16:0]         sum;
  logic                over;
  logic [15:0]         row_inc, j_inc;
  logic                line_end, img_done;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign emit        = slot_free && (state_q inside {S_PIX, S_FIN, S_ERR});

  // Decode the held byte and check the run against the columns left
  assign is_run = !awaiting_q && (byte_q[7:6] == RUN_MARK);
  assign cnt    = is_run ? byte_q[RUN_BITS-1:0]
                         : (awaiting_q ? pending_q : RUN_BITS'(1));
  assign sum    = {1'b0, col_q} + 17'(cnt);
  assign over   = sum > {1'b0, bpl_q};

  // Line and image end for the run that is being placed
  assign row_inc  = row_q + 16'd1;
  assign line_end = end_q >= bpl_q;
  assign img_done = line_end && (row_inc >= height_q);

  // Shared column stepper
  assign j_inc = j_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= 16'd1;
      bpl_q       <= 16'd1;
      height_q    <= 16'd1;
      row_q       <= '0;
      col_q       <= '0;
      pending_q   <= '0;
      awaiting_q  <= 1'b0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the result once taken
      if (out_valid_q && out_ready_i && !emit) begin
        out_valid_q <= 1'b0;
      end

      // Take register writes
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_IMAGE_WIDTH:    width_q  <= cfg_data_i;
          CFG_BYTES_PER_LINE: bpl_q    <= cfg_data_i;
          CFG_IMAGE_HEIGHT:   height_q <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            byte_q <= in_data_i.data_byte;
            if (in_data_i.cmd == CMD_RESTART) begin
              row_q      <= '0;
              col_q      <= '0;
              pending_q  <= '0;
              awaiting_q <= 1'b0;
              halted_q   <= 1'b0;
            end else if (!halted_q && in_data_i.cmd == CMD_END) begin
              err_q    <= ERR_EARLY_END;
              halted_q <= 1'b1;
              state_q  <= S_ERR;
            end else if (!halted_q && in_data_i.cmd == CMD_DATA) begin
              state_q <= S_CHECK;
            end
          end
        end

        S_CHECK: begin
          if (!is_run) begin
            awaiting_q <= 1'b0;
            pending_q  <= '0;
          end
          if (is_run && cnt == '0) begin
            err_q    <= ERR_ZERO_RUN;
            halted_q <= 1'b1;
            state_q  <= S_ERR;
          end else if (over) begin
            err_q    <= ERR_PAST_LINE;
            halted_q <= 1'b1;
            state_q  <= S_ERR;
          end else if (is_run) begin
            pending_q  <= cnt;
            awaiting_q <= 1'b1;
            state_q    <= S_IDLE;
          end else begin
            end_q   <= sum[15:0];
            state_q <= S_LINE;
          end
        end

        S_LINE: begin
          line_end_q <= line_end;
          done_q     <= img_done;
          stop_q     <= (end_q < width_q) ? end_q : width_q;
          j_q        <= col_q;
          if (col_q < width_q) begin
            state_q <= S_PIX;
          end else begin
            // No visible pixel: advance position now
            if (line_end) begin
              col_q <= '0;
              row_q <= row_inc;
            end else begin
              col_q <= end_q;
            end
            if (img_done) begin
              halted_q <= 1'b1;
              state_q  <= S_FIN;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end

        S_PIX: begin
          if (slot_free) begin
            out_valid_q      <= 1'b1;
            out_q.kind       <= KIND_PIXEL;
            out_q.color      <= byte_q;
            out_q.row        <= row_q;
            out_q.column     <= j_q;
            out_q.error_code <= ERR_NONE;
            out_q.last       <= (j_inc == stop_q) && !done_q;
            if (j_inc == stop_q) begin
              if (line_end_q) begin
                col_q <= '0;
                row_q <= row_inc;
              end else begin
                col_q <= end_q;
              end
              if (done_q) begin
                halted_q <= 1'b1;
                state_q  <= S_FIN;
              end else begin
                state_q <= S_IDLE;
              end
            end else begin
              j_q <= j_inc;
            end
          end
        end

        S_FIN: begin
          if (slot_free) begin
            out_valid_q      <= 1'b1;
            out_q.kind       <= KIND_DONE;
            out_q.color      <= '0;
            out_q.row        <= '0;
            out_q.column     <= '0;
            out_q.error_code <= ERR_NONE;
            out_q.last       <= 1'b1;
            state_q          <= S_IDLE;
          end
        end

        S_ERR: begin
          if (slot_free) begin
            out_valid_q      <= 1'b1;
            out_q.kind       <= KIND_ERROR;
            out_q.color      <= '0;
            out_q.row        <= row_q;
            out_q.column     <= col_q;
            out_q.error_code <= err_q;
            out_q.last       <= 1'b1;
            state_q          <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Pixel stepping stays inside the visible part of the run
  a_pix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PIX |-> j_q < stop_q)
    else $error("pixel column beyond run stop");

  // Final results are only produced with the block halted
  a_halt_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN || state_q == S_ERR) |-> halted_q)
    else $error("final result without halt");

  // A stored run count is never zero
  a_pending_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> pending_q != '0)
    else $error("awaiting colour with zero count");

  // The last pixel of a run leaves the pixel state
  a_pix_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PIX && slot_free && j_inc == stop_q |=> state_q != S_PIX)
    else $error("pixel loop did not end");
`endif

endmodule
